/* rtl/sha1_pkg.sv */
// Shared types, constants and round functions of the SHA-1 hash engine.
package sha1_pkg;

	localparam int WORD_W = 32;

	localparam logic [5:0] LEN_POS     = 6'd56;
	localparam logic [5:0] BLOCK_LAST  = 6'd63;
	localparam logic [2:0] DIGEST_LAST = 3'd4;
	localparam logic [6:0] ROUND_LAST  = 7'd79;
	localparam logic [7:0] PAD_BYTE    = 8'h80;

	localparam logic [4:0][WORD_W-1:0] H_INIT = {
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	localparam logic [WORD_W-1:0] K_0 = 32'h5A827999;
	localparam logic [WORD_W-1:0] K_1 = 32'h6ED9EBA1;
	localparam logic [WORD_W-1:0] K_2 = 32'h8F1BBCDC;
	localparam logic [WORD_W-1:0] K_3 = 32'hCA62C1D6;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PAD,
		S_ZERO,
		S_LEN,
		S_ROUND,
		S_FOLD,
		S_OUT
	} sha1_state_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_data;
		logic       last;
	} sha1_in_t;

	typedef struct packed {
		logic [WORD_W-1:0] digest_word;
		logic [2:0]        word_index;
		logic              last_word;
	} sha1_out_t;

	// sequencer to round unit
	typedef struct packed {
		logic              push;
		logic [WORD_W-1:0] word;
		logic              start;
		logic              step;
		logic              fold;
		logic              init;
	} sha1_ctl_t;

	function automatic logic [WORD_W-1:0] round_k(input logic [6:0] rnd);
		logic [WORD_W-1:0] k;
		if (rnd < 7'd20)
			k = K_0;
		else if (rnd < 7'd40)
			k = K_1;
		else if (rnd < 7'd60)
			k = K_2;
		else
			k = K_3;
		return k;
	endfunction

	function automatic logic [WORD_W-1:0] round_f(input logic [6:0] rnd,
			input logic [WORD_W-1:0] b, input logic [WORD_W-1:0] c,
			input logic [WORD_W-1:0] d);
		logic [WORD_W-1:0] f;
		if (rnd < 7'd20)
			f = (b & c) | (~b & d);
		else if (rnd >= 7'd40 && rnd < 7'd60)
			f = (b & c) | (b & d) | (c & d);
		else
			f = b ^ c ^ d;
		return f;
	endfunction

endpackage

/* rtl/sha1_stream_if.sv */
// Valid/ready stream channel carrying one request payload.
interface sha1_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

/* rtl/sha1_hash_engine.sv */
// SHA-1 hash engine top level: byte intake, padding sequencer and digest output.
//
//  channel | dir | payload                              | handshake
//  msg     | in  | data_byte[7:0], has_data, last       | valid/ready
//  dig     | out | digest_word[31:0], word_index, last_word | valid/ready
//
// A byte request is taken in S_IDLE; every 64th byte runs the 80 rounds of the shared
// round unit and the chaining fold. The end of a message feeds padding and length
// one byte a cycle through the same path, pausing while a block runs, runs one or two
// blocks, then offers five digest words, one per cycle while dig is ready.
// msg is not ready during padding, while a block runs or while the digest is offered.
// Reset loads the initial chaining words and clears the byte count and length.
module sha1_hash_engine
	import sha1_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	sha1_stream_if.sink   msg,
	sha1_stream_if.source dig
);

	sha1_state_t state_q, state_d;
	sha1_state_t ret_q, ret_d;
	logic [5:0]  fill_q;
	logic [23:0] acc_q;
	logic [63:0] bits_q;
	logic [2:0]  oidx_q;

	sha1_ctl_t   ctl;
	logic        rnd_last;
	logic [4:0][WORD_W-1:0] chain;

	logic        absorb;
	logic [7:0]  abyte;
	logic [5:0]  fill_d;
	logic        msg_acc;
	logic        dig_acc;
	logic        bits_add;
	logic        bits_shift;
	logic        out_done;
	sha1_state_t after_pad;

	sha1_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.rnd_last (rnd_last),
		.chain    (chain)
	);

	assign msg_acc   = msg.valid && msg.ready;
	assign dig_acc   = dig.valid && dig.ready;
	assign fill_d    = fill_q + 6'd1;
	assign after_pad = (fill_d == LEN_POS) ? S_LEN : S_ZERO;

	assign dig.payload.digest_word = chain[oidx_q];
	assign dig.payload.word_index  = oidx_q;
	assign dig.payload.last_word   = (oidx_q == DIGEST_LAST);

	always_comb begin
		state_d    = state_q;
		ret_d      = ret_q;
		absorb     = 1'b0;
		abyte      = 8'h00;
		bits_add   = 1'b0;
		bits_shift = 1'b0;
		out_done   = 1'b0;
		msg.ready  = 1'b0;
		dig.valid  = 1'b0;
		ctl        = '0;
		case (state_q)
			S_IDLE: begin
				msg.ready = 1'b1;
				if (msg_acc) begin
					state_d = msg.payload.last ? S_PAD : S_IDLE;
					if (msg.payload.has_data) begin
						absorb   = 1'b1;
						abyte    = msg.payload.data_byte;
						bits_add = 1'b1;
					end
				end
			end
			S_PAD: begin
				absorb  = 1'b1;
				abyte   = PAD_BYTE;
				state_d = after_pad;
			end
			S_ZERO: begin
				absorb  = 1'b1;
				state_d = after_pad;
			end
			S_LEN: begin
				absorb     = 1'b1;
				abyte      = bits_q[63:56];
				bits_shift = 1'b1;
				state_d    = S_OUT;
			end
			S_ROUND: begin
				ctl.step = 1'b1;
				if (rnd_last)
					state_d = S_FOLD;
			end
			S_FOLD: begin
				ctl.fold = 1'b1;
				state_d  = ret_q;
			end
			S_OUT: begin
				dig.valid = 1'b1;
				if (dig_acc && oidx_q == DIGEST_LAST) begin
					out_done = 1'b1;
					ctl.init = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		// last length byte always closes a block, so S_OUT is only reached via it
		if (state_q == S_LEN && fill_q != BLOCK_LAST)
			state_d = S_LEN;
		ctl.push = absorb && (fill_q[1:0] == 2'd3);
		ctl.word = {acc_q, abyte};
		if (absorb && fill_q == BLOCK_LAST) begin
			ctl.start = 1'b1;
			ret_d     = state_d;
			state_d   = S_ROUND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			fill_q  <= '0;
			bits_q  <= '0;
			oidx_q  <= '0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			if (absorb)
				fill_q <= fill_d;
			if (out_done)
				bits_q <= '0;
			else if (bits_add)
				bits_q <= bits_q + 64'd8;
			else if (bits_shift)
				bits_q <= {bits_q[55:0], 8'h00};
			if (out_done)
				oidx_q <= '0;
			else if (dig_acc)
				oidx_q <= oidx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (absorb)
			acc_q <= {acc_q[15:0], abyte};
	end

`ifndef NO_ASSERTIONS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(msg.ready && dig.valid))
		else $error("intake open while digest is offered");

	a_len_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LEN) |-> (fill_q[5:3] == 3'd7))
		else $error("length bytes not at end of block");

	a_out_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |-> (fill_q == 6'd0 && bits_q == 64'd0))
		else $error("block state not drained before digest");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(dig_acc && dig.payload.last_word) |=> (msg.ready && oidx_q == 3'd0))
		else $error("engine not idle after final digest word");

	a_round_ret: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROUND) |-> (ret_q != S_ROUND && ret_q != S_FOLD))
		else $error("bad resume state for compression");
`endif

endmodule

/* rtl/sha1_core.sv */
// SHA-1 round unit: schedule shift line, working words and chaining words.
module sha1_core
	import sha1_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  sha1_ctl_t                ctl,
	output logic                     rnd_last,
	output logic [4:0][WORD_W-1:0]   chain
);

	logic [WORD_W-1:0] sched_q [16];
	logic [4:0][WORD_W-1:0] wv_q;
	logic [4:0][WORD_W-1:0] chain_q;
	logic [6:0] rnd_q;

	logic [WORD_W-1:0] w_mix;
	logic [WORD_W-1:0] w_t;
	logic [WORD_W-1:0] t_sum;
	logic [WORD_W-1:0] push_word;

	assign w_mix     = sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0];
	assign w_t       = (rnd_q < 7'd16) ? sched_q[0] : {w_mix[WORD_W-2:0], w_mix[WORD_W-1]};
	assign t_sum     = {wv_q[0][WORD_W-6:0], wv_q[0][WORD_W-1:WORD_W-5]}
		+ round_f(rnd_q, wv_q[1], wv_q[2], wv_q[3]) + wv_q[4] + round_k(rnd_q) + w_t;
	assign push_word = ctl.step ? w_t : ctl.word;
	assign rnd_last  = (rnd_q == ROUND_LAST);
	assign chain     = chain_q;

	always_ff @(posedge clk) begin
		if (ctl.push || ctl.step) begin
			for (int i = 0; i < 15; i++)
				sched_q[i] <= sched_q[i+1];
			sched_q[15] <= push_word;
		end
		if (ctl.start) begin
			wv_q <= chain_q;
		end else if (ctl.step) begin
			wv_q[0] <= t_sum;
			wv_q[1] <= wv_q[0];
			wv_q[2] <= {wv_q[1][1:0], wv_q[1][WORD_W-1:2]};
			wv_q[3] <= wv_q[2];
			wv_q[4] <= wv_q[3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= H_INIT;
			rnd_q   <= '0;
		end else begin
			if (ctl.init) begin
				chain_q <= H_INIT;
			end else if (ctl.fold) begin
				for (int i = 0; i < 5; i++)
					chain_q[i] <= chain_q[i] + wv_q[i];
			end
			if (ctl.start)
				rnd_q <= '0;
			else if (ctl.step)
				rnd_q <= rnd_q + 7'd1;
		end
	end

endmodule
